[hdl/gkd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkd_pkg: shared constants of the 2-D Gaussian kernel density block
// Holds the e^-(2^k/256) factor table, register indexes and field widths.
// ----------------------------------------------------------------------------
package gkd_pkg;

    localparam int COORD_W   = 16;
    localparam int D2_W      = 34;
    localparam int U_W       = 12;
    localparam int KERN_W    = 17;
    localparam int SUM_W     = 23;
    localparam int DENS_W    = 32;
    localparam int IDX_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;
    localparam int SIG_W     = 32;
    localparam int NRM_W     = 24;

    localparam logic [CFG_IDX_W-1:0] REG_INV_TWO_SIGMA_SQ = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_SCALE       = 1'd1;

    localparam logic [SIG_W-1:0] INV_TWO_SIGMA_SQ_RST = 32'd171196;
    localparam logic [NRM_W-1:0] NORM_SCALE_RST       = 24'd54494;

    function automatic logic [15:0] exp_factor(input logic [3:0] k);
        logic [15:0] f;
        case (k)
            4'd0:    f = 16'd65280;
            4'd1:    f = 16'd65026;
            4'd2:    f = 16'd64520;
            4'd3:    f = 16'd63520;
            4'd4:    f = 16'd61565;
            4'd5:    f = 16'd57835;
            4'd6:    f = 16'd51039;
            4'd7:    f = 16'd39750;
            4'd8:    f = 16'd24109;
            4'd9:    f = 16'd8869;
            4'd10:   f = 16'd1200;
            4'd11:   f = 16'd22;
            default: f = 16'd0;
        endcase
        return f;
    endfunction

endpackage

[hdl/gkd_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkd_div: restoring divider, one quotient bit per cycle
// Divides a 47-bit dividend by a count scaled by 2^16; the quotient fits 32 bits.
// ----------------------------------------------------------------------------
module gkd_div
    import gkd_pkg::*;
#(
    parameter int CNT_W = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [46:0]         i_dividend,
    input  logic [CNT_W-1:0]    i_count,
    output logic                o_done,
    output logic [DENS_W-1:0]   o_quot
);

    localparam int NUM_W = 47;
    localparam int QI_W  = NUM_W - 16;
    localparam int STP_W = $clog2(QI_W + 1);

    logic [NUM_W-1:0]  r_num, n_num;
    logic [CNT_W:0]    r_rem, n_rem;
    logic [QI_W-1:0]   r_q, n_q;
    logic [STP_W-1:0]  r_step, n_step;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W+1:0]  w_trial;

    // quotient = floor((num >> 16) / count), since divisor is count * 2^16
    always_comb begin
        n_num   = r_num;
        n_rem   = r_rem;
        n_q     = r_q;
        n_step  = r_step;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem, r_num[NUM_W-1]};
        if (i_start) begin
            n_num  = i_dividend;
            n_rem  = '0;
            n_step = STP_W'(QI_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[NUM_W-2:0], 1'b0};
            if (w_trial >= {1'b0, 1'b0, i_count}) begin
                n_rem = (CNT_W+1)'(w_trial - {2'b0, i_count});
                n_q   = {r_q[QI_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[CNT_W:0];
                n_q   = {r_q[QI_W-2:0], 1'b0};
            end
            n_step = r_step - 1'b1;
            if (r_step == STP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_step <= n_step;
    end

    assign o_done = r_done;
    assign o_quot = DENS_W'(r_q);

endmodule

[hdl/gkd_kernel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkd_kernel: iterative pair kernel unit
// Squares distance, scales by 1/(2 sigma^2), then walks 12 exponent bits with
// a 17x16 multiplier.
// ----------------------------------------------------------------------------
module gkd_kernel
    import gkd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [COORD_W-1:0]  i_xa,
    input  logic signed [COORD_W-1:0]  i_ya,
    input  logic signed [COORD_W-1:0]  i_xb,
    input  logic signed [COORD_W-1:0]  i_yb,
    input  logic [SIG_W-1:0]           i_inv_sig,
    output logic                       o_done,
    output logic [KERN_W-1:0]          o_kernel
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQX  = 6'b000010,
        S_SQY  = 6'b000100,
        S_MHI  = 6'b001000,
        S_MLO  = 6'b010000,
        S_EXP  = 6'b100000
    } t_kst;

    t_kst               r_st, n_st;
    logic signed [16:0] r_dx, r_dy;
    logic [D2_W-1:0]    r_d2;
    logic [49:0]        r_hi;
    logic [U_W-1:0]     r_u;
    logic [KERN_W-1:0]  r_acc;
    logic [3:0]         r_k;
    logic               r_done;
    logic               w_big;

    logic signed [16:0] w_sq_a;
    logic [33:0]        w_sq;
    logic [49:0]        w_mhi;
    logic [49:0]        w_mlo;
    logic [32:0]        w_emul;
    logic [51:0]        w_usum;

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (i_start) n_st = S_SQX;
            S_SQX:   n_st = S_SQY;
            S_SQY:   n_st = S_MHI;
            S_MHI:   n_st = S_MLO;
            S_MLO:   n_st = S_EXP;
            S_EXP:   if (r_k == 4'd11 || w_big) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    assign w_sq_a = (r_st == S_SQX) ? r_dx : r_dy;
    assign w_sq   = 34'(w_sq_a * w_sq_a);
    assign w_mhi  = 50'(r_d2) * 50'(i_inv_sig[31:16]);
    assign w_mlo  = 50'(r_d2) * 50'(i_inv_sig[15:0]);
    assign w_usum = 52'(r_hi) + 52'(w_mlo >> 16);
    assign w_emul = 33'(r_acc) * 33'(exp_factor(r_k)) + 33'd32768;
    assign w_big  = (r_st == S_EXP) && (r_hi[49:12] != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= (r_st == S_EXP) && (r_k == 4'd11 || w_big);
        end
        case (r_st)
            S_IDLE: begin
                r_dx <= 17'(i_xa) - 17'(i_xb);
                r_dy <= 17'(i_ya) - 17'(i_yb);
                r_d2 <= '0;
            end
            S_SQX: r_d2 <= w_sq;
            S_SQY: r_d2 <= r_d2 + w_sq;
            S_MHI: r_hi <= w_mhi;
            S_MLO: begin
                // hold u (possibly >= 4096) in r_hi for the range check
                r_hi  <= 50'(w_usum >> 16);
                r_u   <= U_W'(w_usum >> 16);
                r_acc <= 17'd65536;
                r_k   <= 4'd0;
            end
            S_EXP: begin
                if (w_big) begin
                    r_acc <= '0;
                end else if (r_u[r_k]) begin
                    r_acc <= KERN_W'(w_emul >> 16);
                end
                r_k <= r_k + 4'd1;
            end
            default: ;
        endcase
    end

    assign o_done   = r_done;
    assign o_kernel = r_acc;

endmodule

[hdl/gaussian_kernel_density_2d_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_kernel_density_2d_top: 2-D Gaussian kernel density estimator
// Usage:
//   Input words carry one point (x, y in signed Q8.8) and a last mark. Points
//   are stored until the last mark; points beyond MAX_POINTS are dropped.
//   After the last word the block emits one density word per stored point,
//   in load order, with its index and a last flag on the final one.
// Sequence:
//   Loading accepts one word per cycle. Each pair evaluation runs a memory
//   read, kernel start, coordinate differences, two squares, two scale
//   products, twelve exponent steps, done and accumulate; the exponent steps
//   stop after the first when the exponent is out of range. Each density sums
//   the kernel over all stored points, then runs a bit-serial divide.
//   The input is not ready while densities are computed.
// Reset: clears the point count, the sequencer, and loads sigma-7 defaults.
// Stall: a density word is held in the output register until taken; the
//   sequencer waits before emitting the next one. After the final word the
//   input is ready again while that word waits.
// Configuration writes are taken at any edge with i_cfg_we high outside reset.
// ----------------------------------------------------------------------------
module gaussian_kernel_density_2d_top
    import gkd_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DAT_W-1:0]       i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [COORD_W-1:0]  i_x_coord,
    input  logic signed [COORD_W-1:0]  i_y_coord,
    input  logic                       i_last_point,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [DENS_W-1:0]          o_density,
    output logic [IDX_W-1:0]           o_point_index,
    output logic                       o_last_result
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_RDI   = 7'b0000010,
        S_RDJ   = 7'b0000100,
        S_KERN  = 7'b0001000,
        S_ACC   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_st;

    t_st                 r_st, n_st;
    logic [SIG_W-1:0]    r_inv_sig;
    logic [NRM_W-1:0]    r_norm;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_i, r_j;
    logic [SUM_W-1:0]    r_sum;
    logic [46:0]         r_prod;
    logic                r_wait;

    logic [COORD_W-1:0]  r_xmem [MAX_POINTS];
    logic [COORD_W-1:0]  r_ymem [MAX_POINTS];
    logic [COORD_W-1:0]  r_xrd, r_yrd;
    logic [COORD_W-1:0]  r_xi, r_yi;
    logic [AW-1:0]       w_rd_addr;

    logic                r_kstart, r_dstart;
    logic                w_kdone, w_ddone;
    logic [KERN_W-1:0]   w_kern;
    logic [DENS_W-1:0]   w_quot;
    logic [SUM_W:0]      w_sum_nx;

    logic                r_ovalid;
    logic [DENS_W-1:0]   r_dens;
    logic [IDX_W-1:0]    r_idx;
    logic                r_olast;
    logic                w_in_acc;

    assign o_ready  = (r_st == S_LOAD);
    assign w_in_acc = i_valid && o_ready;
    assign w_sum_nx = (SUM_W+1)'(r_sum) + (SUM_W+1)'(w_kern);
    assign w_rd_addr = (r_st == S_RDI) ? r_i[AW-1:0] : r_j[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (r_cnt < CNT_W'(MAX_POINTS))) begin
            r_xmem[r_cnt[AW-1:0]] <= i_x_coord;
            r_ymem[r_cnt[AW-1:0]] <= i_y_coord;
        end
        r_xrd <= r_xmem[w_rd_addr];
        r_yrd <= r_ymem[w_rd_addr];
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_LOAD:  if (w_in_acc && i_last_point) n_st = S_RDI;
            S_RDI:   n_st = S_RDJ;
            S_RDJ:   n_st = S_KERN;
            S_KERN:  if (w_kdone) n_st = S_ACC;
            S_ACC:   n_st = (r_j == r_cnt - 1'b1) ? S_DIV : S_RDJ;
            S_DIV:   if (w_ddone) n_st = S_OUT;
            S_OUT:   if (!r_ovalid) n_st = (r_i == r_cnt - 1'b1) ? S_LOAD : S_RDI;
            default: n_st = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_LOAD;
            r_inv_sig <= INV_TWO_SIGMA_SQ_RST;
            r_norm    <= NORM_SCALE_RST;
            r_cnt     <= '0;
            r_ovalid  <= 1'b0;
            r_kstart  <= 1'b0;
            r_dstart  <= 1'b0;
            r_wait    <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_kstart <= 1'b0;
            r_dstart <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_INV_TWO_SIGMA_SQ) r_inv_sig <= i_cfg_data;
                if (i_cfg_idx == REG_NORM_SCALE)       r_norm <= i_cfg_data[NRM_W-1:0];
            end
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            case (r_st)
                S_LOAD: begin
                    if (w_in_acc && r_cnt < CNT_W'(MAX_POINTS)) r_cnt <= r_cnt + 1'b1;
                    r_i <= '0;
                    r_j <= '0;
                end
                S_RDI: begin
                    r_sum <= '0;
                    r_j   <= '0;
                end
                S_RDJ: begin
                    r_xi <= (r_j == '0) ? r_xrd : r_xi;
                    r_yi <= (r_j == '0) ? r_yrd : r_yi;
                    r_wait <= 1'b1;
                end
                S_KERN: begin
                    if (r_wait) begin
                        r_kstart <= 1'b1;
                        r_wait   <= 1'b0;
                    end
                    if (w_kdone) r_sum <= w_sum_nx[SUM_W] ? '1 : w_sum_nx[SUM_W-1:0];
                end
                S_ACC: begin
                    r_j <= r_j + 1'b1;
                    if (r_j == r_cnt - 1'b1) begin
                        r_prod   <= 47'(r_sum) * 47'(r_norm);
                        r_dstart <= 1'b1;
                    end
                end
                S_OUT: if (!r_ovalid) begin
                    r_ovalid <= 1'b1;
                    r_dens   <= w_quot;
                    r_idx    <= r_i[IDX_W-1:0];
                    r_olast  <= (r_i == r_cnt - 1'b1);
                    r_i      <= r_i + 1'b1;
                    if (r_i == r_cnt - 1'b1) r_cnt <= '0;
                end
                default: ;
            endcase
        end
    end

    // the read of point i lands in S_RDJ on the first pair; point j is read there
    logic [COORD_W-1:0] w_xa, w_ya;
    assign w_xa = (r_j == '0) ? r_xrd : r_xi;
    assign w_ya = (r_j == '0) ? r_yrd : r_yi;

    logic [COORD_W-1:0] r_xa, r_ya, r_xb, r_yb;
    always_ff @(posedge i_clk) begin
        if (r_st == S_RDJ) begin
            r_xa <= w_xa;
            r_ya <= w_ya;
        end
        if (r_st == S_KERN && r_wait) begin
            r_xb <= r_xrd;
            r_yb <= r_yrd;
        end
    end

    gkd_kernel u_kernel (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_kstart),
        .i_xa      (r_xa),
        .i_ya      (r_ya),
        .i_xb      (r_xb),
        .i_yb      (r_yb),
        .i_inv_sig (r_inv_sig),
        .o_done    (w_kdone),
        .o_kernel  (w_kern)
    );

    gkd_div #(.CNT_W(CNT_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dstart),
        .i_dividend (r_prod),
        .i_count    (r_cnt),
        .o_done     (w_ddone),
        .o_quot     (w_quot)
    );

    assign o_valid       = r_ovalid;
    assign o_density     = r_dens;
    assign o_point_index = r_idx;
    assign o_last_result = r_olast;

endmodule

[hdl/gkd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkd_checker: port-level checks for the density block
// Watches the handshakes and the order of emitted density words.
// ----------------------------------------------------------------------------
module gkd_checker
    import gkd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [IDX_W-1:0]  o_point_index,
    input logic              o_last_result,
    input logic [DENS_W-1:0] o_density
);

    logic              r_seen;
    logic [IDX_W-1:0]  r_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_next <= '0;
        end else if (o_valid && i_ready) begin
            r_seen <= 1'b1;
            r_next <= o_last_result ? '0 : o_point_index + 1'b1;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_density))
        else $error("density word dropped while stalled");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_seen |-> o_point_index == r_next)
        else $error("density index out of order");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ready |-> o_last_result)
        else $error("input ready while densities pending");

endmodule

bind gaussian_kernel_density_2d_top gkd_checker u_gkd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_point_index (o_point_index),
    .o_last_result (o_last_result),
    .o_density     (o_density)
);
